[rtl/core/sws_pkg.sv]
package sws_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_EOW  = 2'd1;
  localparam logic [1:0] KIND_EOL  = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_last;
  } sws_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       last_of_run;
  } sws_out_t;

  // Up to three results per byte: a leading char or end of word, a closing
  // end of word, and an end of line.
  typedef struct packed {
    logic       has_first;
    logic       first_eow;
    logic [7:0] first_char;
    logic       has_eow;
    logic       has_eol;
  } sws_plan_t;

  typedef struct packed {
    logic      push;
    sws_plan_t plan;
  } sws_push_t;

endpackage

[rtl/core/sws_front.sv]
module sws_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sws_pkg::sws_in_t in_data,
  input  logic             queue_full,
  output sws_pkg::sws_push_t push_req
);
  import sws_pkg::*;

  typedef enum logic [2:0] {
    Q_NONE   = 3'b001,
    Q_SINGLE = 3'b010,
    Q_DOUBLE = 3'b100
  } quote_t;

  logic   escape_pending, escape_pending_next;
  logic   word_nonempty, word_nonempty_next;
  quote_t quote_mode, quote_mode_next;

  logic   accept;
  logic   is_bslash, is_sep, is_quote;
  logic   is_sq, is_dq;
  logic   wn_after;
  sws_plan_t plan;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_sq     = (in_data.char_in == CH_SQUOTE) &&
                (quote_mode == Q_NONE || quote_mode == Q_SINGLE);
    is_dq     = (in_data.char_in == CH_DQUOTE) &&
                (quote_mode == Q_NONE || quote_mode == Q_DOUBLE);
    is_bslash = !escape_pending && (in_data.char_in == CH_BSLASH);
    is_sep    = !escape_pending && (in_data.char_in == CH_SPACE) && (quote_mode == Q_NONE);
    is_quote  = !escape_pending && (is_sq || is_dq);

    escape_pending_next = escape_pending;
    quote_mode_next     = quote_mode;
    wn_after            = word_nonempty;
    plan                = '0;

    if (is_bslash) begin
      escape_pending_next = 1'b1;
    end else if (is_sep) begin
      plan.has_first = word_nonempty;
      plan.first_eow = 1'b1;
      wn_after       = 1'b0;
    end else if (is_quote) begin
      plan.has_first = word_nonempty;
      plan.first_eow = 1'b1;
      wn_after       = 1'b0;
      if (quote_mode == Q_NONE) begin
        quote_mode_next = is_sq ? Q_SINGLE : Q_DOUBLE;
      end else begin
        quote_mode_next = Q_NONE;
      end
    end else begin
      escape_pending_next = 1'b0;
      plan.has_first      = 1'b1;
      plan.first_char     = in_data.char_in;
      wn_after            = 1'b1;
    end

    word_nonempty_next = wn_after;

    // End of line: close the pending word, flag end of line, drop all state.
    if (in_data.line_last) begin
      plan.has_eow        = wn_after;
      plan.has_eol        = 1'b1;
      escape_pending_next = 1'b0;
      quote_mode_next     = Q_NONE;
      word_nonempty_next  = 1'b0;
    end

    push_req.plan = plan;
    push_req.push = accept && (plan.has_first || plan.has_eow || plan.has_eol);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      quote_mode     <= Q_NONE;
      word_nonempty  <= 1'b0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
      quote_mode     <= quote_mode_next;
      word_nonempty  <= word_nonempty_next;
    end
  end

endmodule

[rtl/core/sws_queue.sv]
module sws_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sws_pkg::sws_push_t   push_req,
  output logic                 full,
  output logic                 nonempty,
  output sws_pkg::sws_plan_t   head,
  input  logic                 pop
);
  import sws_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  sws_plan_t     entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == FULL_CNT);
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];
  assign do_push  = push_req.push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req.plan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/sws_back.sv]
module sws_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               nonempty,
  input  sws_pkg::sws_plan_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sws_pkg::sws_out_t  out_data
);
  import sws_pkg::*;

  // Slot 0 leading result, slot 1 closing end of word, slot 2 end of line.
  logic [2:0] done, done_next;
  logic [2:0] slots, remaining, pick;
  logic       accept;

  always_comb begin
    slots     = {head.has_eol, head.has_eow, head.has_first};
    remaining = slots & ~done;
    pick      = remaining & (~remaining + 3'd1);

    out_valid = nonempty;
    accept    = out_valid && out_ready;

    out_data = '0;
    if (pick[0]) begin
      out_data.kind     = head.first_eow ? KIND_EOW : KIND_CHAR;
      out_data.char_out = head.first_eow ? 8'd0 : head.first_char;
    end else if (pick[1]) begin
      out_data.kind = KIND_EOW;
    end else begin
      out_data.kind = KIND_EOL;
    end
    out_data.last_of_run = (remaining == pick);

    pop       = accept && (remaining == pick);
    done_next = pop ? 3'b000 : (done | pick);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 3'b000;
    end else if (accept) begin
      done <= done_next;
    end
  end

endmodule

[rtl/core/shell_word_splitter.sv]
// Shell word splitter: bytes in, word characters / end of word / end of line out.
// A taken byte's plan is registered in the plan queue; its first result is
// offered once that plan heads the queue. Throughput: one byte per cycle while
// out_ready holds and no byte gives over one result; a byte with more results
// holds the output, and QUEUE_DEPTH queued plans absorb that before input stalls.
// Reset (rst, synchronous): no quote open, no escape, empty word, queue emptied.
module shell_word_splitter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sws_pkg::sws_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sws_pkg::sws_out_t out_data
);
  import sws_pkg::*;

  sws_push_t push_req;
  sws_plan_t head;
  logic      queue_full;
  logic      queue_nonempty;
  logic      pop;

  // Front: classify each byte against escape / quote / word state and turn it
  // into a plan of up to three results. Bytes that give nothing are dropped here.
  sws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push_req   (push_req)
  );

  // Plan queue: decouples the front, one byte a cycle while the queue has room, from the result stream.
  sws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_req (push_req),
    .full     (queue_full),
    .nonempty (queue_nonempty),
    .head     (head),
    .pop      (pop)
  );

  // Back: walk the head plan one result per handshake and retire it on the last.
  sws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (queue_nonempty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
